[design/elliptical_region_mean_color_defines.svh]
// Assertion helpers for the modules that check themselves; erm_ctrl is the only user.
// Each macro expects clk and rst_n in scope.
`ifndef ELLIPTICAL_REGION_MEAN_COLOR_DEFINES_SVH
`define ELLIPTICAL_REGION_MEAN_COLOR_DEFINES_SVH

// same-cycle implication
`define ERM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ERM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/erm_pkg.sv]
`timescale 1ns / 1ps

package erm_pkg;

    localparam int MAX_DIM    = 4096;

    localparam int COORD_W    = 12;
    localparam int EDGE_W     = 13;
    localparam int PIX_W      = 8;
    localparam int SQ_W       = 24;
    localparam int WT_W       = 24;
    localparam int PROD_W     = SQ_W + WT_W;
    localparam int DIST_W     = PROD_W + 1;
    localparam int SUM_W      = 32;
    localparam int CNT_W      = 25;

    localparam int IN_DATA_W  = 2 * COORD_W + 3 * PIX_W;
    localparam int OUT_DATA_W = ((3 * PIX_W + CNT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 4;

    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [EDGE_W-1:0] EDGE_MAX = EDGE_W'(MAX_DIM);

    localparam logic [CFG_IDX_W-1:0] REG_RECT_LEFT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RECT_RIGHT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RECT_TOP    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RECT_BOTTOM = CFG_IDX_W'(3);

    typedef enum logic [1:0] {
        DSEL_WEIGHT,
        DSEL_LUMA,
        DSEL_CB,
        DSEL_CR
    } erm_dsel_t;

    typedef struct packed {
        logic      load_pix;
        logic      geo_sq;
        logic      geo_set;
        logic      div_start;
        logic      div_store;
        erm_dsel_t div_sel;
        logic      pix_sq;
        logic      pix_mul;
        logic      pix_acc;
        logic      out_err;
        logic      out_set;
        logic      frame_clear;
    } erm_cmd_t;

    typedef struct packed {
        logic frame_active;
        logic axis_zero;
        logic err_end;
        logic last;
        logic div_done;
        logic out_busy;
    } erm_stat_t;

endpackage

[design/elliptical_region_mean_color.sv]
// Each pixel is captured, squared, weight-multiplied and accumulated in turn; a new pixel is
// taken only after the accumulate. The first pixel of a frame adds geometry set-up, plus the
// weight divide when both half-axes are nonzero; the radix-2 divider retires one quotient bit
// per cycle. At frame end the block waits for the result register to be free, then runs three
// serial divides for the means (none on error); the result sits in an output register while
// the next frame's pixels are taken. tvalid rises when the last mean or the error is stored.
// Reset: asynchronous, active low; clears edge registers, sums, count and all control state.
`timescale 1ns / 1ps

module elliptical_region_mean_color
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pixel_col, pixel_row, pixel_luma, pixel_cb, pixel_cr
    input  logic [erm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // mean_luma, mean_cb, mean_cr, selected_count, zero pad
    output logic [erm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // region_error
    output logic                            m_axis_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [erm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [erm_pkg::EDGE_W-1:0]      cfg_data
);
    import erm_pkg::*;

    erm_cmd_t  cmd;
    erm_stat_t stat;

    assign cfg_ready = 1'b1;

    erm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    erm_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

endmodule

[design/erm_div.sv]
`timescale 1ns / 1ps

module erm_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [erm_pkg::SUM_W-1:0]   dividend,
    input  logic [erm_pkg::CNT_W-1:0]   divisor,
    output logic                        done,
    output logic [erm_pkg::SUM_W-1:0]   quotient
);
    import erm_pkg::*;

    logic [SUM_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     rem_reg;
    logic [CNT_W-1:0]     dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [CNT_W:0]       rem_sh;
    logic                 ge;
    logic [CNT_W-1:0]     rem_next;
    logic [SUM_W-1:0]     quo_next;

    // restoring radix-2 step, one quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
        ge       = (rem_sh >= {1'b0, dsr_reg});
        rem_next = ge ? CNT_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/erm_dp.sv]
`timescale 1ns / 1ps

module erm_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [erm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    input  logic                            cfg_valid,
    input  logic [erm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [erm_pkg::EDGE_W-1:0]      cfg_data,
    input  logic                            m_axis_tready,
    output logic                            m_axis_tvalid,
    output logic [erm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tuser,
    input  erm_pkg::erm_cmd_t               cmd,
    output erm_pkg::erm_stat_t              stat
);
    import erm_pkg::*;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - PIX_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] clamp_mean(input logic [SUM_W-1:0] q);
        return (|q[SUM_W-1:PIX_W]) ? {PIX_W{1'b1}} : q[PIX_W-1:0];
    endfunction

    // edge registers
    logic [COORD_W-1:0] rect_left_reg;
    logic [EDGE_W-1:0]  rect_right_reg;
    logic [COORD_W-1:0] rect_top_reg;
    logic [EDGE_W-1:0]  rect_bottom_reg;

    // captured pixel
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [PIX_W-1:0]   luma_reg;
    logic [PIX_W-1:0]   cb_reg;
    logic [PIX_W-1:0]   cr_reg;
    logic               last_reg;

    // frame geometry
    logic               frame_active_reg;
    logic               axis_error_reg;
    logic [COORD_W-1:0] center_col_reg;
    logic [COORD_W-1:0] center_row_reg;
    logic [SQ_W-1:0]    hx2_reg;
    logic [SQ_W-1:0]    hy2_reg;
    logic [SQ_W-1:0]    radius_reg;
    logic [WT_W-1:0]    wcol_reg;
    logic [WT_W-1:0]    wrow_reg;

    // per-pixel pipeline
    logic               in_rect_reg;
    logic [SQ_W-1:0]    dx2_reg;
    logic [SQ_W-1:0]    dy2_reg;
    logic [PROD_W-1:0]  px_reg;
    logic [PROD_W-1:0]  py_reg;

    // accumulators
    logic [SUM_W-1:0]   sum_luma_reg;
    logic [SUM_W-1:0]   sum_cb_reg;
    logic [SUM_W-1:0]   sum_cr_reg;
    logic [CNT_W-1:0]   count_reg;

    // result register
    logic               out_valid_reg;
    logic [PIX_W-1:0]   out_luma_reg;
    logic [PIX_W-1:0]   out_cb_reg;
    logic [PIX_W-1:0]   out_cr_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic               out_err_reg;

    // operand of the divide in flight
    erm_dsel_t          div_sel_reg;

    logic [EDGE_W-1:0]  right_sat;
    logic [EDGE_W-1:0]  bottom_sat;
    logic [EDGE_W-1:0]  dist_x;
    logic [EDGE_W-1:0]  dist_y;
    logic [COORD_W-1:0] half_x;
    logic [COORD_W-1:0] half_y;
    logic [EDGE_W:0]    csum_x;
    logic [EDGE_W:0]    csum_y;
    logic [EDGE_W-1:0]  dx_s;
    logic [EDGE_W-1:0]  dy_s;
    logic [COORD_W-1:0] dx_mag;
    logic [COORD_W-1:0] dy_mag;
    logic               in_rect_c;
    logic [DIST_W-1:0]  ell_dist;
    logic               hit;
    logic               hx_lt;
    logic               axis_zero;

    logic               div_done;
    logic [SUM_W-1:0]   div_quo;
    logic [SUM_W-1:0]   div_dividend;
    logic [CNT_W-1:0]   div_divisor;

    always_comb
    begin
        right_sat  = (rect_right_reg > EDGE_MAX) ? EDGE_MAX : rect_right_reg;
        bottom_sat = (rect_bottom_reg > EDGE_MAX) ? EDGE_MAX : rect_bottom_reg;

        // half-axis magnitude works for reversed edges too
        dist_x = (right_sat >= {1'b0, rect_left_reg}) ? right_sat - {1'b0, rect_left_reg}
                                                     : {1'b0, rect_left_reg} - right_sat;
        dist_y = (bottom_sat >= {1'b0, rect_top_reg}) ? bottom_sat - {1'b0, rect_top_reg}
                                                     : {1'b0, rect_top_reg} - bottom_sat;
        half_x = dist_x[EDGE_W-1:1];
        half_y = dist_y[EDGE_W-1:1];
        csum_x = {2'b00, rect_left_reg} + {1'b0, right_sat};
        csum_y = {2'b00, rect_top_reg} + {1'b0, bottom_sat};

        dx_s   = {1'b0, col_reg} - {1'b0, center_col_reg};
        dy_s   = {1'b0, row_reg} - {1'b0, center_row_reg};
        dx_mag = dx_s[EDGE_W-1] ? COORD_W'(-dx_s) : dx_s[COORD_W-1:0];
        dy_mag = dy_s[EDGE_W-1] ? COORD_W'(-dy_s) : dy_s[COORD_W-1:0];

        in_rect_c = (col_reg >= rect_left_reg) && ({1'b0, col_reg} < right_sat)
                 && (row_reg >= rect_top_reg) && ({1'b0, row_reg} < bottom_sat);

        ell_dist = {1'b0, px_reg} + {1'b0, py_reg};
        // a zero half-axis leaves all weights zero, so gate on the error bit
        hit  = in_rect_reg && !axis_error_reg
            && (ell_dist <= {{(DIST_W - SQ_W){1'b0}}, radius_reg});

        hx_lt     = (hx2_reg < hy2_reg);
        axis_zero = (hx2_reg == '0) || (hy2_reg == '0);

        unique case (cmd.div_sel)
            DSEL_WEIGHT:
            begin
                div_dividend = {{(SUM_W - SQ_W){1'b0}}, (hx_lt ? hy2_reg : hx2_reg)};
                div_divisor  = {{(CNT_W - SQ_W){1'b0}}, (hx_lt ? hx2_reg : hy2_reg)};
            end
            DSEL_LUMA:
            begin
                div_dividend = sum_luma_reg;
                div_divisor  = count_reg;
            end
            DSEL_CB:
            begin
                div_dividend = sum_cb_reg;
                div_divisor  = count_reg;
            end
            DSEL_CR:
            begin
                div_dividend = sum_cr_reg;
                div_divisor  = count_reg;
            end
            default:
            begin
                div_dividend = sum_luma_reg;
                div_divisor  = count_reg;
            end
        endcase
    end

    erm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // control and reset-bearing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg    <= '0;
            rect_right_reg   <= '0;
            rect_top_reg     <= '0;
            rect_bottom_reg  <= '0;
            frame_active_reg <= 1'b0;
            axis_error_reg   <= 1'b0;
            sum_luma_reg     <= '0;
            sum_cb_reg       <= '0;
            sum_cr_reg       <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_RECT_LEFT:   rect_left_reg   <= cfg_data[COORD_W-1:0];
                    REG_RECT_RIGHT:  rect_right_reg  <= cfg_data;
                    REG_RECT_TOP:    rect_top_reg    <= cfg_data[COORD_W-1:0];
                    REG_RECT_BOTTOM: rect_bottom_reg <= cfg_data;
                    default:         ;
                endcase
            end

            if (cmd.geo_sq)
            begin
                frame_active_reg <= 1'b1;
                sum_luma_reg     <= '0;
                sum_cb_reg       <= '0;
                sum_cr_reg       <= '0;
                count_reg        <= '0;
            end
            else if (cmd.pix_acc && hit)
            begin
                sum_luma_reg <= sat_add(sum_luma_reg, luma_reg);
                sum_cb_reg   <= sat_add(sum_cb_reg, cb_reg);
                sum_cr_reg   <= sat_add(sum_cr_reg, cr_reg);
                if (count_reg != {CNT_W{1'b1}})
                    count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.frame_clear)
            begin
                frame_active_reg <= 1'b0;
                sum_luma_reg     <= '0;
                sum_cb_reg       <= '0;
                sum_cr_reg       <= '0;
                count_reg        <= '0;
            end

            if (cmd.geo_set)
                axis_error_reg <= axis_zero;

            if (cmd.out_err || cmd.out_set)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            col_reg  <= s_axis_tdata[11:0];
            row_reg  <= s_axis_tdata[23:12];
            luma_reg <= s_axis_tdata[31:24];
            cb_reg   <= s_axis_tdata[39:32];
            cr_reg   <= s_axis_tdata[47:40];
            last_reg <= s_axis_tlast;
        end

        // the next divide may start in the beat the previous quotient is stored
        if (cmd.div_start)
            div_sel_reg <= cmd.div_sel;

        if (cmd.geo_sq)
        begin
            hx2_reg        <= {{(SQ_W - COORD_W){1'b0}}, half_x}
                            * {{(SQ_W - COORD_W){1'b0}}, half_x};
            hy2_reg        <= {{(SQ_W - COORD_W){1'b0}}, half_y}
                            * {{(SQ_W - COORD_W){1'b0}}, half_y};
            center_col_reg <= csum_x[EDGE_W-1:1];
            center_row_reg <= csum_y[EDGE_W-1:1];
        end

        if (cmd.geo_set)
        begin
            if (axis_zero)
            begin
                radius_reg <= '0;
                wcol_reg   <= '0;
                wrow_reg   <= '0;
            end
            else if (hx_lt)
            begin
                radius_reg <= hy2_reg;
                wcol_reg   <= '0;
                wrow_reg   <= WT_W'(1);
            end
            else
            begin
                radius_reg <= hx2_reg;
                wcol_reg   <= WT_W'(1);
                wrow_reg   <= '0;
            end
        end

        if (cmd.div_store)
        begin
            unique case (div_sel_reg)
                DSEL_WEIGHT:
                begin
                    if (hx_lt)
                        wcol_reg <= div_quo[WT_W-1:0];
                    else
                        wrow_reg <= div_quo[WT_W-1:0];
                end
                DSEL_LUMA: out_luma_reg <= clamp_mean(div_quo);
                DSEL_CB:   out_cb_reg   <= clamp_mean(div_quo);
                DSEL_CR:   out_cr_reg   <= clamp_mean(div_quo);
                default:   ;
            endcase
        end

        if (cmd.pix_sq)
        begin
            in_rect_reg <= in_rect_c;
            dx2_reg     <= {{(SQ_W - COORD_W){1'b0}}, dx_mag}
                         * {{(SQ_W - COORD_W){1'b0}}, dx_mag};
            dy2_reg     <= {{(SQ_W - COORD_W){1'b0}}, dy_mag}
                         * {{(SQ_W - COORD_W){1'b0}}, dy_mag};
        end

        if (cmd.pix_mul)
        begin
            px_reg <= {{(PROD_W - SQ_W){1'b0}}, dx2_reg} * {{(PROD_W - WT_W){1'b0}}, wcol_reg};
            py_reg <= {{(PROD_W - SQ_W){1'b0}}, dy2_reg} * {{(PROD_W - WT_W){1'b0}}, wrow_reg};
        end

        if (cmd.out_err)
        begin
            out_luma_reg  <= '0;
            out_cb_reg    <= '0;
            out_cr_reg    <= '0;
            out_count_reg <= count_reg;
            out_err_reg   <= 1'b1;
        end
        else if (cmd.out_set)
        begin
            out_count_reg <= count_reg;
            out_err_reg   <= 1'b0;
        end
    end

    assign stat.frame_active = frame_active_reg;
    assign stat.axis_zero    = axis_zero;
    assign stat.err_end      = axis_error_reg || (count_reg == '0);
    assign stat.last         = last_reg;
    assign stat.div_done     = div_done;
    assign stat.out_busy     = out_valid_reg;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - CNT_W - 3 * PIX_W){1'b0}},
                            out_count_reg, out_cr_reg, out_cb_reg, out_luma_reg};
    assign m_axis_tuser  = out_err_reg;

endmodule

[design/erm_ctrl.sv]
`timescale 1ns / 1ps
`include "elliptical_region_mean_color_defines.svh"

module erm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  erm_pkg::erm_stat_t  stat,
    output erm_pkg::erm_cmd_t   cmd
);
    import erm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GEO_SQ,
        S_GEO_SET,
        S_GEO_DIV,
        S_PIX_SQ,
        S_PIX_MUL,
        S_PIX_ACC,
        S_FIN,
        S_DIV_Y,
        S_DIV_CB,
        S_DIV_CR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pix = 1'b1;
                    state_next   = stat.frame_active ? S_PIX_SQ : S_GEO_SQ;
                end
            end
            S_GEO_SQ:
            begin
                cmd.geo_sq = 1'b1;
                state_next = S_GEO_SET;
            end
            S_GEO_SET:
            begin
                cmd.geo_set = 1'b1;
                cmd.div_sel = DSEL_WEIGHT;
                if (stat.axis_zero)
                    state_next = S_PIX_SQ;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_GEO_DIV;
                end
            end
            S_GEO_DIV:
            begin
                cmd.div_sel = DSEL_WEIGHT;
                if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    state_next    = S_PIX_SQ;
                end
            end
            S_PIX_SQ:
            begin
                cmd.pix_sq = 1'b1;
                state_next = S_PIX_MUL;
            end
            S_PIX_MUL:
            begin
                cmd.pix_mul = 1'b1;
                state_next  = S_PIX_ACC;
            end
            S_PIX_ACC:
            begin
                cmd.pix_acc = 1'b1;
                state_next  = stat.last ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                // means go straight into the result register, so it must be free
                cmd.div_sel = DSEL_LUMA;
                if (!stat.out_busy)
                begin
                    if (stat.err_end)
                    begin
                        cmd.out_err     = 1'b1;
                        cmd.frame_clear = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV_Y;
                    end
                end
            end
            S_DIV_Y:
            begin
                if (stat.div_done)
                begin
                    cmd.div_sel   = DSEL_LUMA;
                    cmd.div_store = 1'b1;
                    state_next    = S_DIV_CB;
                end
            end
            S_DIV_CB:
            begin
                if (stat.div_done)
                begin
                    cmd.div_sel   = DSEL_CB;
                    cmd.div_store = 1'b1;
                    state_next    = S_DIV_CR;
                end
            end
            S_DIV_CR:
            begin
                cmd.div_sel = DSEL_CR;
                if (stat.div_done)
                begin
                    cmd.div_store   = 1'b1;
                    cmd.out_set     = 1'b1;
                    cmd.frame_clear = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // next divide starts in the beat the previous one reports done
        if (state_reg == S_DIV_Y && stat.div_done)
        begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_CB;
        end
        if (state_reg == S_DIV_CB && stat.div_done)
        begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DSEL_CR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    `ERM_ASSERT_IMP(a_done_while_waiting, stat.div_done, (state_reg == S_GEO_DIV || state_reg == S_DIV_Y || state_reg == S_DIV_CB || state_reg == S_DIV_CR), "divider done outside a wait state")
    `ERM_ASSERT_IMP(a_result_reg_free, (cmd.out_set || cmd.out_err), !stat.out_busy, "result written while previous result pending")
    `ERM_ASSERT_NXT(a_accept_leaves_idle, (state_reg == S_IDLE && in_valid), state_reg != S_IDLE, "accepted beat did not start processing")

endmodule

[test/erm_checker.sv]
`timescale 1ns / 1ps

module erm_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // pixel_col, pixel_row, pixel_luma, pixel_cb, pixel_cr
    input  logic [erm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // mean_luma, mean_cb, mean_cr, selected_count, zero pad
    input  logic [erm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // region_error
    input  logic                            m_axis_tuser,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [erm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [erm_pkg::EDGE_W-1:0]      cfg_data,
    output int                              fail_count,
    output int                              pending,
    output int                              results_checked,
    output int                              error_results
);

    import erm_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] cb;
        logic [PIX_W-1:0] cr;
        logic [CNT_W-1:0] count;
        logic             err;
    } roi_mean_t;

    roi_mean_t mean_queue[$];

    // register copies
    logic [COORD_W-1:0] left_q;
    logic [EDGE_W-1:0]  right_q;
    logic [COORD_W-1:0] top_q;
    logic [EDGE_W-1:0]  bottom_q;

    // per-frame ellipse and accumulators
    logic [SUM_W-1:0]   acc_luma;
    logic [SUM_W-1:0]   acc_cb;
    logic [SUM_W-1:0]   acc_cr;
    logic [CNT_W-1:0]   hit_count;
    logic [COORD_W-1:0] ctr_col;
    logic [COORD_W-1:0] ctr_row;
    logic [SQ_W-1:0]    rad_sq;
    logic [WT_W-1:0]    wt_col;
    logic [WT_W-1:0]    wt_row;
    bit                 in_frame;
    bit                 axis_bad;

    // scratch
    logic [COORD_W-1:0] px_col;
    logic [COORD_W-1:0] px_row;
    logic [PIX_W-1:0]   px_luma;
    logic [PIX_W-1:0]   px_cb;
    logic [PIX_W-1:0]   px_cr;
    logic [EDGE_W-1:0]  lim_col;
    logic [EDGE_W-1:0]  lim_row;
    int unsigned        span_col;
    int unsigned        span_row;
    int unsigned        hx2;
    int unsigned        hy2;
    longint             dcol;
    longint             drow;
    longint unsigned    ell_dist;
    bit                 bad;
    roi_mean_t          want_mean;
    roi_mean_t          got_mean;

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [PIX_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + b;
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] clamp_mean(logic [SUM_W-1:0] total,
                                                   logic [CNT_W-1:0] n);
        logic [SUM_W-1:0] q;
        q = total / n;
        return (q > 255) ? '1 : q[PIX_W-1:0];
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_q          = '0;
            right_q         = '0;
            top_q           = '0;
            bottom_q        = '0;
            acc_luma        = '0;
            acc_cb          = '0;
            acc_cr          = '0;
            hit_count       = '0;
            ctr_col         = '0;
            ctr_row         = '0;
            rad_sq          = '0;
            wt_col          = '0;
            wt_row          = '0;
            in_frame        = 1'b0;
            axis_bad        = 1'b0;
            mean_queue.delete();
            fail_count      = 0;
            results_checked = 0;
            error_results   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RECT_LEFT:   left_q   = cfg_data[COORD_W-1:0];
                    REG_RECT_RIGHT:  right_q  = cfg_data;
                    REG_RECT_TOP:    top_q    = cfg_data[COORD_W-1:0];
                    REG_RECT_BOTTOM: bottom_q = cfg_data;
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                {px_cr, px_cb, px_luma, px_row, px_col} = s_axis_tdata;
                lim_col = (right_q > EDGE_MAX) ? EDGE_MAX : right_q;
                lim_row = (bottom_q > EDGE_MAX) ? EDGE_MAX : bottom_q;

                // geometry is taken from the registers on the first beat of a frame
                if (!in_frame)
                begin
                    span_col = (lim_col >= left_q) ? lim_col - left_q : left_q - lim_col;
                    span_row = (lim_row >= top_q) ? lim_row - top_q : top_q - lim_row;
                    hx2 = (span_col / 2) * (span_col / 2);
                    hy2 = (span_row / 2) * (span_row / 2);
                    ctr_col = COORD_W'((int'(left_q) + int'(lim_col)) / 2);
                    ctr_row = COORD_W'((int'(top_q) + int'(lim_row)) / 2);
                    if (hx2 == 0 || hy2 == 0)
                    begin
                        axis_bad = 1'b1;
                        rad_sq   = '0;
                        wt_col   = '0;
                        wt_row   = '0;
                    end
                    else if (hx2 < hy2)
                    begin
                        axis_bad = 1'b0;
                        rad_sq   = SQ_W'(hy2);
                        wt_col   = WT_W'(hy2 / hx2);
                        wt_row   = WT_W'(1);
                    end
                    else
                    begin
                        axis_bad = 1'b0;
                        rad_sq   = SQ_W'(hx2);
                        wt_col   = WT_W'(1);
                        wt_row   = WT_W'(hx2 / hy2);
                    end
                    acc_luma  = '0;
                    acc_cb    = '0;
                    acc_cr    = '0;
                    hit_count = '0;
                    in_frame  = 1'b1;
                end

                if (!axis_bad && px_col >= left_q && px_col < lim_col &&
                    px_row >= top_q && px_row < lim_row)
                begin
                    dcol = longint'(px_col) - longint'(ctr_col);
                    drow = longint'(px_row) - longint'(ctr_row);
                    ell_dist = longint'(dcol * dcol) * wt_col + longint'(drow * drow) * wt_row;
                    if (ell_dist <= rad_sq)
                    begin
                        acc_luma = sat_sum(acc_luma, px_luma);
                        acc_cb   = sat_sum(acc_cb, px_cb);
                        acc_cr   = sat_sum(acc_cr, px_cr);
                        if (hit_count != '1)
                            hit_count++;
                    end
                end

                if (s_axis_tlast)
                begin
                    bad = axis_bad || hit_count == 0;
                    want_mean.err   = bad;
                    want_mean.count = hit_count;
                    want_mean.luma  = bad ? '0 : clamp_mean(acc_luma, hit_count);
                    want_mean.cb    = bad ? '0 : clamp_mean(acc_cb, hit_count);
                    want_mean.cr    = bad ? '0 : clamp_mean(acc_cr, hit_count);
                    mean_queue.push_back(want_mean);
                    in_frame  = 1'b0;
                    acc_luma  = '0;
                    acc_cb    = '0;
                    acc_cr    = '0;
                    hit_count = '0;
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got_mean.luma  = m_axis_tdata[PIX_W-1:0];
                got_mean.cb    = m_axis_tdata[2*PIX_W-1:PIX_W];
                got_mean.cr    = m_axis_tdata[3*PIX_W-1:2*PIX_W];
                got_mean.count = m_axis_tdata[3*PIX_W+CNT_W-1:3*PIX_W];
                got_mean.err   = m_axis_tuser;
                if (mean_queue.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %p", $time, got_mean);
                    fail_count++;
                end
                else
                begin
                    want_mean = mean_queue.pop_front();
                    results_checked++;
                    if (want_mean.err)
                        error_results++;
                    check_field("mean_luma", want_mean.luma, got_mean.luma);
                    check_field("mean_cb", want_mean.cb, got_mean.cb);
                    check_field("mean_cr", want_mean.cr, got_mean.cr);
                    check_field("selected_count", want_mean.count, got_mean.count);
                    check_field("region_error", want_mean.err, got_mean.err);
                end
            end
        end
        pending = mean_queue.size();
    end

endmodule

[test/tb_elliptical_region_mean_color.sv]
`timescale 1ns / 1ps

module tb_elliptical_region_mean_color;

    import erm_pkg::*;

    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 200;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DIRECTED_PHASES = 6;
    localparam int EDGE_TOP        = (1 << EDGE_W) - 1;
    localparam int IDX_TOP         = (1 << CFG_IDX_W) - 1;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(9);

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [EDGE_W-1:0]     cfg_data;

    int fail_count;
    int pending;
    int results_checked;
    int error_results;
    int pixels_sent;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;

    // current rectangle, used only to aim the random pixels
    int cur_left;
    int cur_right;
    int cur_top;
    int cur_bottom;

    elliptical_region_mean_color u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    erm_checker u_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .error_results   (error_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb_elliptical_region_mean_color: FAIL");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!rx_idle_en)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 18);
        end
    end

    // leaves cfg_valid high so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= EDGE_W'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_rect(input int l, input int r, input int t, input int b);
        write_reg(REG_RECT_LEFT, l);
        write_reg(REG_RECT_RIGHT, r);
        write_reg(REG_RECT_TOP, t);
        write_reg(REG_RECT_BOTTOM, b);
        cfg_valid  <= 1'b0;
        cur_left   = l;
        cur_right  = r;
        cur_top    = t;
        cur_bottom = b;
    endtask

    task automatic send_pixel(input int col, input int row, input int y, input int cb,
                              input int cr, input bit last);
        while (tx_idle_en && $urandom_range(99) < 18)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {PIX_W'(cr), PIX_W'(cb), PIX_W'(y), COORD_W'(row), COORD_W'(col)};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // mostly around the rectangle so the ellipse test is exercised, some anywhere
    task automatic send_frame(input int n_pix);
        int lo_c;
        int hi_c;
        int lo_r;
        int hi_r;
        int c;
        int r;
        lo_c = ((cur_left < cur_right) ? cur_left : cur_right) - 2;
        hi_c = ((cur_left > cur_right) ? cur_left : cur_right) + 1;
        lo_r = ((cur_top < cur_bottom) ? cur_top : cur_bottom) - 2;
        hi_r = ((cur_top > cur_bottom) ? cur_top : cur_bottom) + 1;
        if (lo_c < 0) lo_c = 0;
        if (lo_r < 0) lo_r = 0;
        if (hi_c > MAX_DIM - 1) hi_c = MAX_DIM - 1;
        if (hi_r > MAX_DIM - 1) hi_r = MAX_DIM - 1;
        for (int i = 0; i < n_pix; i++)
        begin
            if ($urandom_range(9) == 0)
            begin
                c = $urandom_range(MAX_DIM - 1);
                r = $urandom_range(MAX_DIM - 1);
            end
            else
            begin
                c = $urandom_range(hi_c, lo_c);
                r = $urandom_range(hi_r, lo_r);
            end
            send_pixel(c, r, $urandom_range(255), $urandom_range(255), $urandom_range(255),
                       i == n_pix - 1);
        end
    endtask

    // block is idle once every mean is back and the divider has had time to finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int sent;
        int n;
        int l;
        int r;
        int t;
        int b;

        pixels_sent = 0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset rectangle has zero half-axes
        cur_left = 0; cur_right = 0; cur_top = 0; cur_bottom = 0;
        send_pixel(0, 0, 0, 0, 0, 1'b0);
        send_pixel(MAX_DIM - 1, MAX_DIM - 1, 255, 255, 255, 1'b1);
        settle();

        // wide ellipse: center (20,23), hx2 100, hy2 9, row weight 11
        write_reg(REG_UNMAPPED, EDGE_TOP);
        set_rect(10, 30, 20, 26);
        send_pixel(20, 23, 255, 0, 128, 1'b0);
        send_pixel(10, 23, 0, 255, 1, 1'b0);
        send_pixel(30, 23, 7, 7, 7, 1'b0);
        send_pixel(20, 26, 9, 9, 9, 1'b0);
        send_pixel(11, 21, 200, 100, 50, 1'b0);
        send_pixel(20, 20, 1, 2, 3, 1'b1);
        send_pixel(20, 23, 77, 88, 99, 1'b1);
        send_pixel(0, 0, 255, 255, 255, 1'b0);
        send_pixel(MAX_DIM - 1, MAX_DIM - 1, 255, 255, 255, 1'b1);
        settle();

        // tall ellipse: column weight 100
        set_rect(100, 104, 0, 40);
        send_pixel(102, 0, 10, 20, 30, 1'b0);
        send_pixel(100, 20, 40, 50, 60, 1'b0);
        send_pixel(103, 39, 255, 255, 255, 1'b0);
        send_pixel(101, 21, 0, 0, 0, 1'b1);
        settle();

        // right and bottom edges beyond the image saturate
        set_rect(4000, EDGE_TOP, 4090, EDGE_TOP);
        send_pixel(MAX_DIM - 1, MAX_DIM - 1, 255, 255, 255, 1'b0);
        send_pixel(4048, 4093, 128, 64, 32, 1'b0);
        send_pixel(MAX_DIM - 1, 4093, 255, 254, 253, 1'b1);
        settle();

        // reversed rectangle
        set_rect(50, 20, 5, 60);
        send_pixel(30, 30, 100, 100, 100, 1'b0);
        send_pixel(60, 10, 100, 100, 100, 1'b1);
        settle();

        // one column wide: zero horizontal half-axis
        set_rect(7, 8, 0, 100);
        send_pixel(7, 50, 90, 90, 90, 1'b1);
        settle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if ($urandom_range(1) == 1)
                write_reg(CFG_IDX_W'($urandom_range(IDX_TOP, int'(REG_RECT_BOTTOM) + 1)),
                          $urandom_range(EDGE_TOP));
            if (ph == 0)
                set_rect(0, MAX_DIM, 0, MAX_DIM);
            else if (ph == 1)
                set_rect(MAX_DIM - 1, EDGE_TOP, MAX_DIM - 1, EDGE_TOP);
            else
            begin
                l = $urandom_range(MAX_DIM - 1);
                r = l + (($urandom_range(3) == 0) ? $urandom_range(600) : $urandom_range(40));
                t = $urandom_range(MAX_DIM - 1);
                b = t + (($urandom_range(3) == 0) ? $urandom_range(600) : $urandom_range(40));
                if ($urandom_range(9) == 0) r = $urandom_range(EDGE_TOP);
                if ($urandom_range(9) == 0) b = $urandom_range(EDGE_TOP);
                set_rect(l, r, t, b);
            end

            // a stretch with no idling on either side
            tx_idle_en = (ph != 5 && ph != 6);
            rx_idle_en = tx_idle_en;
            // long result stall while pixels keep coming, so the input backs up
            if (ph == 3)
                hold_req = 1'b1;

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                n = $urandom_range(12, 1);
                send_frame(n);
                sent += n;
            end
            settle();
        end

        $display("covered %0d pixels over %0d fixed and %0d random region settings",
                 pixels_sent, DIRECTED_PHASES, RANDOM_PHASES);
        $display("checked %0d frame means, %0d of them flagged as region errors",
                 results_checked, error_results);
        if (fail_count == 0 && pending == 0)
            $display("tb_elliptical_region_mean_color: PASS");
        else
            $display("tb_elliptical_region_mean_color: FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/erm_pkg.sv
design/erm_div.sv
design/erm_dp.sv
design/erm_ctrl.sv
design/elliptical_region_mean_color.sv
test/erm_checker.sv
test/tb_elliptical_region_mean_color.sv
